### design/jet_pkg.sv
// Package for the Julia escape-time block: formats, codes and the log2 table.
// Used by every module under design/; no dependencies.
package jet_pkg;

  localparam int FracBits  = 27;
  localparam int LogTabN   = 256;
  localparam int LogIdxW   = $clog2(LogTabN);
  localparam int Q16One    = 65536;
  localparam int NegLog2Ln2 = 34653;

  // configuration register indexes
  localparam logic [1:0] CfgCRe   = 2'd0;
  localparam logic [1:0] CfgCIm   = 2'd1;
  localparam logic [1:0] CfgLimit = 2'd2;
  localparam logic [1:0] CfgRad   = 2'd3;

  // log2(1 + i/N) in Q16 by repeated squaring in Q30; last entry is 1.0
  function automatic logic [16:0] log_tab(input logic [LogIdxW:0] i);
    logic [63:0] x;
    logic [16:0] r;
    if (i >= (LogIdxW+1)'(LogTabN)) begin
      log_tab = 17'(Q16One);
    end else begin
      x = (64'd1 << 30) + ((64'(i) << 30) / LogTabN);
      r = '0;
      for (int b = 0; b < 16; b++) begin
        x = (x * x) >> 30;
        r = r << 1;
        if (x >= (64'd1 << 31)) begin
          r[0] = 1'b1;
          x = x >> 1;
        end
      end
      log_tab = r;
    end
  endfunction

endpackage

### design/jet_log2.sv
// Multi-cycle log2 unit: leading-one search a nibble per cycle, table, lerp.
// Depends on jet_pkg. Result is log2(v) in Q16 relative to bit 0 (caller subtracts q).
module jet_log2 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] v_i,
  output logic        done_o,
  output logic signed [23:0] log_o
);
  typedef enum logic [3:0] {
    L_IDLE = 4'b0001, L_SRCH = 4'b0010, L_LOOK = 4'b0100, L_MUL = 4'b1000
  } lstate_e;

  lstate_e     st_q, st_d;
  logic [63:0] v_q, v_d;
  logic [5:0]  p_q, p_d;
  logic [31:0] f_q;
  logic [16:0] lo_q, hi_q;
  logic [16:0] tab [0:jet_pkg::LogTabN];
  logic [jet_pkg::LogIdxW:0] tab_idx;
  logic [95:0] sh_w;

  // constant log2 table, folded at elaboration
  for (genvar g = 0; g <= jet_pkg::LogTabN; g++) begin : g_tab
    localparam logic [16:0] TabVal = jet_pkg::log_tab((jet_pkg::LogIdxW+1)'(g));
    assign tab[g] = TabVal;
  end

  // bits below the leading one, left justified (position as found this cycle)
  assign sh_w    = {v_q, 32'd0} << (7'd64 - 7'(p_d));
  assign tab_idx = {1'b0, f_q[31 -: jet_pkg::LogIdxW]};

  always_comb begin
    st_d = st_q;
    v_d  = v_q;
    p_d  = p_q;
    unique case (st_q)
      L_IDLE: if (start_i) begin
        v_d  = (v_i == 64'd0) ? 64'd1 : v_i;
        p_d  = 6'd63;
        st_d = L_SRCH;
      end
      L_SRCH: begin
        // scan down four bits a cycle
        if (v_q[p_q]) st_d = L_LOOK;
        else if (v_q[p_q-6'd1]) begin p_d = p_q - 6'd1; st_d = L_LOOK; end
        else if (v_q[p_q-6'd2]) begin p_d = p_q - 6'd2; st_d = L_LOOK; end
        else if (v_q[p_q-6'd3]) begin p_d = p_q - 6'd3; st_d = L_LOOK; end
        else p_d = p_q - 6'd4;
      end
      L_LOOK: st_d = L_MUL;
      L_MUL:  st_d = L_IDLE;
      default: st_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= L_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    p_q <= p_d;
    if (st_q == L_SRCH) f_q <= sh_w[95:64];
    if (st_q == L_LOOK) begin
      lo_q <= tab[tab_idx];
      hi_q <= tab[tab_idx + 1'b1];
    end
  end

  // interpolation (hi-lo fits 17 bits, rem 32 bits)
  logic [31:0] rem;
  assign rem = {f_q[31-jet_pkg::LogIdxW:0], {jet_pkg::LogIdxW{1'b0}}};

  assign done_o = (st_q == L_MUL);
  assign log_o  = $signed({2'b00, p_q, 16'd0}) + $signed(24'(lo_q) +
                  24'((49'(hi_q - lo_q) * 49'(rem)) >> 32));
endmodule

### design/julia_escape_time.sv
// Julia escape-time pixel unit: one start per pixel, one result strobe.
// Each iteration runs an S_MUL step (registered products) and then an S_TEST step; a bounded
// point strobes once the limit is reached, and a point that escapes strobes after two log2 passes
// (the leading-one scan covers four bits a cycle).
// A new pixel is taken only once the unit is back in idle; busy is high meanwhile.
// Reset: asynchronous active low; c = 0, limit 256, radius^2 100; the receiver cannot stall.
module julia_escape_time (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic signed [31:0] z_re_i,
  input  logic signed [31:0] z_im_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output logic        done_o,
  output logic [14:0] iteration_count_o,
  output logic        escaped_o,
  output logic signed [31:0] smooth_value_o
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_MUL = 7'b0000010, S_TEST = 7'b0000100,
    S_LOG1 = 7'b0001000, S_LOG2 = 7'b0010000, S_FIN = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

  localparam int Sh = 2 * jet_pkg::FracBits;

  state_e st_q, st_d;
  logic signed [31:0] c_re_q, c_im_q, zr_q, zi_q;
  logic [14:0] lim_q, n_q;
  logic [7:0]  rad_q;
  logic signed [63:0] sr_q, si_q, pr_q;
  logic        esc_q;
  logic signed [31:0] sm_q;
  logic        lg_start;
  logic [63:0] lg_v;
  logic        lg_done;
  logic signed [23:0] lg_out;
  logic signed [23:0] l1_q;

  // configuration
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_re_q <= '0; c_im_q <= '0; lim_q <= 15'd256; rad_q <= 8'd100;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        jet_pkg::CfgCRe:   c_re_q <= cfg_data_i;
        jet_pkg::CfgCIm:   c_im_q <= cfg_data_i;
        jet_pkg::CfgLimit: lim_q  <= cfg_data_i[14:0];
        jet_pkg::CfgRad:   rad_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // escape test and next z
  logic [63:0] mag;
  logic [9:0]  ip;
  logic        fpnz, esc_now;
  logic signed [64:0] dre, nre, nim;
  assign mag  = 64'(sr_q) + 64'(si_q);
  assign ip   = 10'(mag >> Sh);
  assign fpnz = |mag[Sh-1:0];
  assign esc_now = (ip > 10'(rad_q)) || (ip == 10'(rad_q) && fpnz);
  assign dre  = 65'(sr_q) - 65'(si_q);
  assign nre  = (dre >>> jet_pkg::FracBits) + 65'(c_re_q);
  assign nim  = (65'(pr_q) >>> (jet_pkg::FracBits - 1)) + 65'(c_im_q);

  function automatic logic signed [31:0] sat(input logic signed [64:0] v);
    if (v > 65'sd2147483647) sat = 32'sh7fffffff;
    else if (v < -65'sd2147483648) sat = 32'sh80000000;
    else sat = v[31:0];
  endfunction

  // smooth value; the second log pass reads l1 as an integer, so it carries +16.0
  logic signed [23:0] l1c;
  logic signed [47:0] smooth_w;
  assign l1c = (l1_q < 24'sd65536) ? 24'sd65536 : l1_q;
  assign smooth_w = $signed({17'd0, n_q, 16'd0}) + 48'sd131072 +
                    48'(jet_pkg::NegLog2Ln2) - 48'(lg_out) + 48'sd1048576;

  always_comb begin
    st_d = st_q;
    lg_start = 1'b0;
    lg_v = mag;
    unique case (st_q)
      S_IDLE: if (start) st_d = (lim_q == 15'd0) ? S_OUT : S_MUL;
      S_MUL:  st_d = S_TEST;
      S_TEST: if (esc_now) begin st_d = S_LOG1; lg_start = 1'b1; end
              else if (n_q + 15'd1 >= lim_q) st_d = S_OUT;
              else st_d = S_MUL;
      S_LOG1: if (lg_done) st_d = S_FIN;
      S_FIN:  begin lg_start = 1'b1; lg_v = 64'(unsigned'(l1c)); st_d = S_LOG2; end
      S_LOG2: if (lg_done) st_d = S_OUT;
      S_OUT:  st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= S_IDLE;
    else st_q <= st_d;
  end

  // datapath: one complex step per S_MUL/S_TEST pair, with registered products
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      S_IDLE: begin
        zr_q <= z_re_i; zi_q <= z_im_i; n_q <= '0; esc_q <= 1'b0;
        sm_q <= '0;
      end
      S_MUL: begin
        sr_q <= zr_q * zr_q; si_q <= zi_q * zi_q; pr_q <= zr_q * zi_q;
      end
      S_TEST: begin
        if (esc_now) esc_q <= 1'b1;
        else begin
          zr_q <= sat(nre); zi_q <= sat(nim); n_q <= n_q + 15'd1;
          sm_q <= $signed({1'b0, n_q + 15'd1, 16'd0});
        end
      end
      S_LOG1: if (lg_done) l1_q <= lg_out - 24'(Sh * jet_pkg::Q16One);
      S_LOG2: if (lg_done) begin
        if (smooth_w > 48'sd2147483647) sm_q <= 32'sh7fffffff;
        else sm_q <= 32'(smooth_w);
      end
      default: ;
    endcase
  end

  jet_log2 u_log2 (
    .clk_i, .rst_ni, .start_i(lg_start), .v_i(lg_v),
    .done_o(lg_done), .log_o(lg_out)
  );

  assign busy = (st_q != S_IDLE);
  assign done_o = (st_q == S_OUT);
  assign iteration_count_o = (esc_q || st_q != S_OUT) ? n_q : lim_q;
  assign escaped_o = esc_q;
  assign smooth_value_o = sm_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy) else $error("done not followed by idle");
  a_count_le_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> iteration_count_o <= lim_q) else $error("count over limit");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("start not taken");
endmodule

### tb/sv/julia_escape_time_tb.sv
// Self-checking testbench for julia_escape_time: pixel driver, result monitor, predictor.
// Needs design/jet_pkg.sv, design/jet_log2.sv and design/julia_escape_time.sv.
module julia_escape_time_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
  } pixel_t;

  typedef struct packed {
    logic [14:0]        count;
    logic               esc;
    logic signed [31:0] smooth;
  } escape_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic signed [31:0] z_re_i = '0;
  logic signed [31:0] z_im_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        done_o;
  logic [14:0] iteration_count_o;
  logic        escaped_o;
  logic signed [31:0] smooth_value_o;

  julia_escape_time dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor copy of the configuration
  logic signed [31:0] c_re_q = '0;
  logic signed [31:0] c_im_q = '0;
  logic [14:0]        limit_q = 15'd256;
  logic [7:0]         rad_q = 8'd100;

  longint unsigned log_lut [0:jet_pkg::LogTabN];
  pixel_t  pixel_q[$];
  escape_t expect_q[$];
  int      gap_cnt = 0;
  bit      no_idle = 0;
  int      n_err = 0;
  int      n_checked = 0;
  int      n_escaped = 0;

  function automatic longint unsigned lut_entry(int i);
    longint unsigned x;
    longint unsigned r;
    x = (64'd1 << 30) + ((longint'(i) << 30) / jet_pkg::LogTabN);
    r = 0;
    for (int b = 0; b < 16; b++) begin
      x = (x * x) >> 30;
      r = r << 1;
      if (x >= (64'd1 << 31)) begin
        r = r | 1;
        x = x >> 1;
      end
    end
    return r;
  endfunction

  // log2(v / 2^q) in Q16: leading one plus interpolated table
  function automatic longint log2_q16(longint unsigned v, int q);
    int p;
    longint unsigned f;
    longint unsigned rem;
    longint unsigned lo;
    longint unsigned hi;
    int idx;
    if (v == 0) v = 1;
    p = 63;
    while (p > 0 && !v[p]) p--;
    if (p >= 32) f = (v >> (p - 32)) & 64'hffff_ffff;
    else f = (v << (32 - p)) & 64'hffff_ffff;
    idx = int'(f >> 24);
    rem = (f & 64'hff_ffff) << 8;
    lo = log_lut[idx];
    hi = log_lut[idx + 1];
    return longint'(p - q) * jet_pkg::Q16One + longint'(lo + (((hi - lo) * rem) >> 32));
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // full step: keeps old re for the imaginary product
  function automatic escape_t pixel_predict(pixel_t px);
    longint zr;
    longint zi;
    longint sr;
    longint si;
    longint nr;
    longint ni;
    longint unsigned mag;
    longint unsigned ip;
    longint unsigned fp;
    longint l1;
    longint l2;
    int n;
    bit esc;
    escape_t res;
    zr = px.re;
    zi = px.im;
    n = 0;
    esc = 0;
    mag = 0;
    while (n < limit_q) begin
      sr = zr * zr;
      si = zi * zi;
      mag = sr + si;
      ip = mag >> (2 * jet_pkg::FracBits);
      fp = mag & ((64'd1 << (2 * jet_pkg::FracBits)) - 1);
      if (ip > rad_q || (ip == rad_q && fp != 0)) begin
        esc = 1;
        break;
      end
      nr = ((sr - si) >>> jet_pkg::FracBits) + c_re_q;
      ni = ((zr * zi) >>> (jet_pkg::FracBits - 1)) + c_im_q;
      zr = sat32(nr);
      zi = sat32(ni);
      n++;
    end
    if (esc) begin
      l1 = log2_q16(mag, 2 * jet_pkg::FracBits);
      if (l1 < jet_pkg::Q16One) l1 = jet_pkg::Q16One;
      l2 = log2_q16(longint'(l1), 16);
      res.smooth = 32'(sat32(longint'(n) * jet_pkg::Q16One + 2 * jet_pkg::Q16One +
                             jet_pkg::NegLog2Ln2 - l2));
    end else begin
      n = limit_q;
      res.smooth = 32'(longint'(limit_q) * jet_pkg::Q16One);
    end
    res.count = 15'(n);
    res.esc = esc;
    return res;
  endfunction

  // driver: one pixel item per start/busy handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        expect_q.push_back(pixel_predict('{re: z_re_i, im: z_im_i}));
        gap_cnt = no_idle ? 0 : $urandom_range(0, 4);
        if (gap_cnt == 0 && pixel_q.size() > 0) begin
          {z_re_i, z_im_i} <= pixel_q.pop_front();
        end else begin
          start <= 1'b0;
        end
      end else if (!start) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
        end else if (pixel_q.size() > 0) begin
          {z_re_i, z_im_i} <= pixel_q.pop_front();
          start <= 1'b1;
        end
      end
    end
  end

  // monitor: compare each strobed result with the oldest expectation
  always @(posedge clk_i) begin
    escape_t exp_r;
    if (rst_ni && done_o) begin
      if (expect_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected result count=%0d", iteration_count_o);
      end else begin
        exp_r = expect_q.pop_front();
        n_checked++;
        if (exp_r.esc) n_escaped++;
        if (exp_r.count !== iteration_count_o || exp_r.esc !== escaped_o ||
            exp_r.smooth !== smooth_value_o) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch: exp cnt=%0d esc=%0d sm=%0d, got cnt=%0d esc=%0d sm=%0d",
                     exp_r.count, exp_r.esc, exp_r.smooth,
                     iteration_count_o, escaped_o, smooth_value_o);
        end
      end
    end
  end

  task automatic cfg_write(logic [1:0] idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    unique case (idx)
      jet_pkg::CfgCRe:   c_re_q = data;
      jet_pkg::CfgCIm:   c_im_q = data;
      jet_pkg::CfgLimit: limit_q = data[14:0];
      jet_pkg::CfgRad:   rad_q = data[7:0];
      default: ;
    endcase
  endtask

  task automatic set_cfg(logic [31:0] cr, logic [31:0] ci, logic [14:0] lim, logic [7:0] rad);
    cfg_write(jet_pkg::CfgCRe, cr);
    cfg_write(jet_pkg::CfgCIm, ci);
    cfg_write(jet_pkg::CfgLimit, {17'($urandom_range(0, 131071)), lim});
    cfg_write(jet_pkg::CfgRad, {24'($urandom_range(0, 16777215)), rad});
  endtask

  function automatic logic [31:0] coord_rand();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return 32'($urandom_range(0, 1 << 29)) - 32'(1 << 28);
    if (sel < 8) return 32'($urandom_range(0, 1 << 28)) - 32'(1 << 27);
    return $urandom();
  endfunction

  task automatic push_rand(int n);
    for (int i = 0; i < n; i++) pixel_q.push_back('{re: coord_rand(), im: coord_rand()});
  endtask

  task automatic drain();
    while (pixel_q.size() > 0 || start || expect_q.size() > 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  // stimulus: directed corners, then randomized phases
  initial begin
    for (int i = 0; i < jet_pkg::LogTabN; i++) log_lut[i] = lut_entry(i);
    log_lut[jet_pkg::LogTabN] = jet_pkg::Q16One;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    // reset settings: corner points
    pixel_q.push_back('{re: 32'sd0, im: 32'sd0});
    pixel_q.push_back('{re: 32'h7fff_ffff, im: 32'h7fff_ffff});
    pixel_q.push_back('{re: 32'h8000_0000, im: 32'h8000_0000});
    pixel_q.push_back('{re: 32'h7fff_ffff, im: 32'h8000_0000});
    pixel_q.push_back('{re: 32'sd1 << 27, im: 32'sd0});
    pixel_q.push_back('{re: -(32'sd1 << 27), im: 32'sd1});
    drain();
    // Julia constant, radius^2 at four; the exact-boundary point sits on the threshold
    set_cfg(32'(-107374182), 32'(20937965), 15'd200, 8'd4);
    pixel_q.push_back('{re: 32'sd2 << 27, im: 32'sd0});
    pixel_q.push_back('{re: 32'sd1 << 27, im: 32'sd1 << 27});
    push_rand(100);
    drain();
    // largest radius with extreme c: coordinate saturation
    set_cfg(32'h7fff_ffff, 32'h8000_0000, 15'd50, 8'd255);
    pixel_q.push_back('{re: 32'h7f00_0000, im: 32'sd0});
    pixel_q.push_back('{re: 32'sd0, im: 32'sd0});
    push_rand(60);
    drain();
    // single iteration
    set_cfg(32'sd0, 32'sd0, 15'd1, 8'd255);
    push_rand(40);
    drain();
    // zero limit: no iteration
    set_cfg($urandom(), $urandom(), 15'd0, 8'd100);
    push_rand(10);
    drain();
    // zero radius: any nonzero magnitude escapes
    set_cfg(32'sd0, 32'sd0, 15'd20, 8'd0);
    pixel_q.push_back('{re: 32'sd0, im: 32'sd0});
    pixel_q.push_back('{re: 32'sd1, im: 32'sd0});
    push_rand(30);
    drain();
    // largest limit, a few non-escaping points
    set_cfg(32'sd0, 32'sd0, 15'd32767, 8'd4);
    pixel_q.push_back('{re: 32'sd0, im: 32'sd0});
    pixel_q.push_back('{re: 32'sd1 << 26, im: 32'sd0});
    push_rand(4);
    drain();
    // random settings, alternating back-to-back and idling stretches
    for (int ph = 0; ph < 7; ph++) begin
      no_idle = ph[0];
      set_cfg(coord_rand(), coord_rand(), 15'($urandom_range(1, 100)),
              8'($urandom_range(0, 255)));
      push_rand(100);
      drain();
    end
    repeat (100) @(posedge clk_i);
    n_err += expect_q.size();
    $display("checked %0d pixels (%0d escaped) over fourteen settings", n_checked, n_escaped);
    if (n_err == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", n_err);
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

endmodule
